// ----- rtl/integer_radix_to_ascii_macros.svh -----
// Assertion macros used by the back stage of the integer radix to ASCII converter.
`ifndef INTEGER_RADIX_TO_ASCII_MACROS_SVH
`define INTEGER_RADIX_TO_ASCII_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define IRTA_CHECK(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define IRTA_CHECK_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/irta_pkg.sv -----
// Types, constants and helpers of the integer radix to ASCII converter.
package irta_pkg;

    localparam int WORD_BITS = 32;
    localparam int STEP_BITS = 8;
    localparam int WORK_BITS = ((WORD_BITS + STEP_BITS - 1) / STEP_BITS) * STEP_BITS;
    localparam int STEPS     = WORK_BITS / STEP_BITS;
    localparam int STEP_W    = (STEPS > 1) ? $clog2(STEPS) : 1;
    localparam int CNT_W     = $clog2(WORD_BITS + 1);
    localparam int IDX_W     = (WORD_BITS > 1) ? $clog2(WORD_BITS) : 1;

    localparam logic [7:0] RADIX_MIN = 8'd2;
    localparam logic [7:0] RADIX_MAX = 8'd36;

    localparam logic [1:0] STATUS_OK        = 2'd0;
    localparam logic [1:0] STATUS_BAD_RADIX = 2'd1;
    localparam logic [1:0] STATUS_OVERFLOW  = 2'd2;

    typedef enum logic [1:0] {
        K_CONVERT   = 2'd0,
        K_BAD_RADIX = 2'd1,
        K_EMPTY     = 2'd2
    } t_kind;

    typedef struct packed {
        logic signed [31:0] value;
        logic [7:0]         radix;
        logic [15:0]        capacity;
    } t_in_item;

    typedef struct packed {
        logic [7:0] char_code;
        logic       has_char;
        logic       last;
        logic [1:0] status;
    } t_out_item;

    typedef struct packed {
        t_kind                kind;
        logic [WORD_BITS-1:0] num;
        logic [5:0]           radix;
        logic [15:0]          capacity;
    } t_job;

    function automatic logic [WORD_BITS-1:0] to_word(input logic signed [31:0] v);
        logic signed [WORD_BITS+31:0] wide;
        wide = (WORD_BITS + 32)'(v);
        return wide[WORD_BITS-1:0];
    endfunction

    function automatic logic [7:0] glyph(input logic [5:0] d);
        logic [7:0] d8;
        d8 = {2'b00, d};
        if (d < 6'd10) begin
            return 8'h30 + d8;
        end
        return 8'h41 + d8 - 8'd10;
    endfunction

endpackage

// ----- rtl/integer_radix_to_ascii.sv -----
// Top level of the integer radix to ASCII converter.
//
//  channel  handshake       payload     direction
//  input    push / full     t_in_item   in
//  result   empty / pop     t_out_item  out
//
// Error and empty items pass the front register and job queue, then S_FIN.
// A conversion takes the job in S_IDLE, divides in S_DIV (8 quotient bits a cycle)
// and emits one digit per cycle in S_EMIT while the result register is free.
// Reset is synchronous and active low; it clears control state only.
// A front register and a two-entry job queue accept items while the back
// divides; a result register lets the back run while pop is low.
module integer_radix_to_ascii
    import irta_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      push,
    output logic      full,
    input  t_in_item  i_item,
    output logic      empty,
    input  logic      pop,
    output t_out_item o_item
);

    logic f_valid;
    t_job f_job;
    logic q_full;
    logic q_empty;
    logic q_rd;
    t_job q_job;

    irta_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .o_full      (full),
        .i_item      (i_item),
        .o_job_valid (f_valid),
        .o_job       (f_job),
        .i_job_ready (!q_full)
    );

    irta_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_wr     (f_valid),
        .i_wr_job (f_job),
        .o_full   (q_full),
        .i_rd     (q_rd),
        .o_rd_job (q_job),
        .o_empty  (q_empty)
    );

    irta_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job_empty (q_empty),
        .i_job       (q_job),
        .o_job_rd    (q_rd),
        .o_empty     (empty),
        .i_pop       (pop),
        .o_item      (o_item)
    );

endmodule

// ----- rtl/irta_front.sv -----
// Front stage: accepts items, classifies them and registers the job.
module irta_front
    import irta_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_push,
    output logic     o_full,
    input  t_in_item i_item,
    output logic     o_job_valid,
    output t_job     o_job,
    input  logic     i_job_ready
);

    logic r_valid;
    t_job r_job;
    t_job n_job;
    logic take;

    assign o_full      = r_valid && !i_job_ready;
    assign take        = i_push && !o_full;
    assign o_job_valid = r_valid;
    assign o_job       = r_job;

    always_comb begin
        n_job.num      = to_word(i_item.value);
        n_job.radix    = i_item.radix[5:0];
        n_job.capacity = i_item.capacity;
        if (i_item.radix < RADIX_MIN || i_item.radix > RADIX_MAX) begin
            n_job.kind = K_BAD_RADIX;
        end else if (i_item.capacity == 16'd0) begin
            n_job.kind = K_EMPTY;
        end else begin
            n_job.kind = K_CONVERT;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (take) begin
            r_valid <= 1'b1;
        end else if (i_job_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_job <= n_job;
        end
    end

endmodule

// ----- rtl/irta_queue.sv -----
// Two-entry job queue between front and back stages.
module irta_queue
    import irta_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_wr,
    input  t_job i_wr_job,
    output logic o_full,
    input  logic i_rd,
    output t_job o_rd_job,
    output logic o_empty
);

    t_job       r_mem [2];
    logic       r_wp;
    logic       r_rp;
    logic [1:0] r_cnt;
    logic       wr_en;
    logic       rd_en;

    assign o_full   = (r_cnt == 2'd2);
    assign o_empty  = (r_cnt == 2'd0);
    assign wr_en    = i_wr && !o_full;
    assign rd_en    = i_rd && !o_empty;
    assign o_rd_job = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (wr_en) begin
                r_wp <= !r_wp;
            end
            if (rd_en) begin
                r_rp <= !r_rp;
            end
            case ({wr_en, rd_en})
                2'b10:   r_cnt <= r_cnt + 2'd1;
                2'b01:   r_cnt <= r_cnt - 2'd1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[r_wp] <= i_wr_job;
        end
    end

endmodule

// ----- rtl/irta_back.sv -----
// Back stage: digit extraction by iterative division and result output.
`include "integer_radix_to_ascii_macros.svh"

module irta_back
    import irta_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_job_empty,
    input  t_job      i_job,
    output logic      o_job_rd,
    output logic      o_empty,
    input  logic      i_pop,
    output t_out_item o_item
);

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_DIV  = 4'b0010,
        S_FIN  = 4'b0100,
        S_EMIT = 4'b1000
    } t_state;

    t_state               r_state;
    t_state               n_state;
    t_job                 r_job;
    logic [WORK_BITS-1:0] r_work;
    logic [WORK_BITS-1:0] n_work;
    logic [5:0]           r_rem;
    logic [5:0]           n_rem;
    logic [STEP_W-1:0]    r_step;
    logic [STEP_W-1:0]    n_step;
    logic [CNT_W-1:0]     r_cnt;
    logic [CNT_W-1:0]     n_cnt;
    logic [1:0]           r_fin_status;
    logic [1:0]           n_fin_status;
    logic [5:0]           r_digits [WORD_BITS];
    logic                 r_out_valid;
    t_out_item            r_out;
    t_out_item            n_out;

    logic [6:0]           d_rem;
    logic [WORK_BITS-1:0] d_work;
    logic                 out_free;
    logic                 out_load;
    logic                 pass_end;
    logic                 dig_wr;
    logic [CNT_W-1:0]     cnt_inc;
    logic [CNT_W-1:0]     cnt_dec;
    logic [IDX_W-1:0]     rd_idx;

    assign out_free = !r_out_valid || i_pop;
    assign o_empty  = !r_out_valid;
    assign o_item   = r_out;
    assign o_job_rd = (r_state == S_IDLE) && !i_job_empty;
    assign pass_end = (r_step == STEP_W'(STEPS - 1));
    assign cnt_inc  = r_cnt + CNT_W'(1);
    assign cnt_dec  = r_cnt - CNT_W'(1);
    assign rd_idx   = cnt_dec[IDX_W-1:0];
    assign dig_wr   = (r_state == S_DIV) && pass_end;

    always_comb begin
        d_rem  = {1'b0, r_rem};
        d_work = r_work;
        for (int k = 0; k < STEP_BITS; k++) begin
            d_rem  = {d_rem[5:0], d_work[WORK_BITS-1]};
            d_work = {d_work[WORK_BITS-2:0], 1'b0};
            if (d_rem >= {1'b0, r_job.radix}) begin
                d_rem     = d_rem - {1'b0, r_job.radix};
                d_work[0] = 1'b1;
            end
        end
    end

    always_comb begin
        n_state      = r_state;
        n_work       = r_work;
        n_rem        = r_rem;
        n_step       = r_step;
        n_cnt        = r_cnt;
        n_fin_status = r_fin_status;
        out_load     = 1'b0;
        n_out        = '0;
        case (r_state)
            S_IDLE: begin
                if (!i_job_empty) begin
                    n_work = WORK_BITS'(i_job.num);
                    n_rem  = '0;
                    n_step = '0;
                    n_cnt  = '0;
                    case (i_job.kind)
                        K_CONVERT: begin
                            n_state = S_DIV;
                        end
                        K_BAD_RADIX: begin
                            n_fin_status = STATUS_BAD_RADIX;
                            n_state      = S_FIN;
                        end
                        default: begin
                            n_fin_status = STATUS_OK;
                            n_state      = S_FIN;
                        end
                    endcase
                end
            end
            S_DIV: begin
                if (pass_end) begin
                    n_work = d_work;
                    n_rem  = '0;
                    n_step = '0;
                    n_cnt  = cnt_inc;
                    if (d_work == '0 || cnt_inc == CNT_W'(WORD_BITS)) begin
                        if (16'(cnt_inc) > r_job.capacity) begin
                            n_fin_status = STATUS_OVERFLOW;
                            n_state      = S_FIN;
                        end else begin
                            n_state = S_EMIT;
                        end
                    end
                end else begin
                    n_work = d_work;
                    n_rem  = d_rem[5:0];
                    n_step = r_step + STEP_W'(1);
                end
            end
            S_FIN: begin
                if (out_free) begin
                    out_load     = 1'b1;
                    n_out.last   = 1'b1;
                    n_out.status = r_fin_status;
                    n_state      = S_IDLE;
                end
            end
            S_EMIT: begin
                if (out_free) begin
                    out_load        = 1'b1;
                    n_out.char_code = glyph(r_digits[rd_idx]);
                    n_out.has_char  = 1'b1;
                    n_out.last      = (r_cnt == CNT_W'(1));
                    n_out.status    = STATUS_OK;
                    n_cnt           = cnt_dec;
                    if (r_cnt == CNT_W'(1)) begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cnt       <= '0;
            r_step      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_step  <= n_step;
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_pop) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_work       <= n_work;
        r_rem        <= n_rem;
        r_fin_status <= n_fin_status;
        if (o_job_rd) begin
            r_job <= i_job;
        end
        if (dig_wr) begin
            r_digits[r_cnt[IDX_W-1:0]] <= d_rem[5:0];
        end
        if (out_load) begin
            r_out <= n_out;
        end
    end

    `IRTA_CHECK(a_cnt_range, 1'b1, r_cnt <= CNT_W'(WORD_BITS), "digit count out of range")
    `IRTA_CHECK(a_emit_cnt, r_state == S_EMIT, r_cnt != '0, "emitting with no digits left")
    `IRTA_CHECK(a_div_kind, r_state == S_DIV, r_job.kind == K_CONVERT, "dividing a non-convert job")
    `IRTA_CHECK_NEXT(a_emit_done, r_state == S_EMIT && out_free && r_cnt == CNT_W'(1), r_state == S_IDLE, "emit did not finish")

endmodule

// ----- sim/integer_radix_to_ascii_test.sv -----
// Testbench for the integer radix to ASCII converter: directed and random requests.
module integer_radix_to_ascii_test;
    timeunit 1ns;
    timeprecision 1ps;

    import irta_pkg::*;

    localparam int RANDOM_REQUESTS = 200;
    localparam int HOLD_CYCLES     = 600;
    localparam int DRAIN_CYCLES    = 200;
    localparam int CYCLE_LIMIT     = 400000;

    localparam logic [7:0] ASCII_ZERO = "0";
    localparam logic [7:0] ASCII_A    = "A";

    logic      i_clk   = 1'b0;
    logic      i_rst_n = 1'b0;
    logic      push    = 1'b0;
    logic      full;
    t_in_item  i_item  = '0;
    logic      empty;
    logic      pop     = 1'b0;
    t_out_item o_item;

    t_in_item  pending_requests[$];
    t_out_item expected_chars[$];
    logic      item_taken   = 1'b0;
    int        items_sent   = 0;
    int        total_items  = 0;
    int        mismatches   = 0;
    int        cycle_count  = 0;
    int        hold_left    = 0;
    bit        hold_done    = 1'b0;

    integer_radix_to_ascii DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .push    (push),
        .full    (full),
        .i_item  (i_item),
        .empty   (empty),
        .pop     (pop),
        .o_item  (o_item)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic void queue_request(input int v, input int r, input int c);
        t_in_item req;
        req.value    = v;
        req.radix    = r[7:0];
        req.capacity = c[15:0];
        pending_requests.push_back(req);
    endfunction

    function automatic void queue_random_request();
        int v;
        int r;
        int c;
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 20) begin
            v = $urandom_range(0, 40);
        end else if (pick < 30) begin
            v = -int'($urandom_range(1, 40));
        end else begin
            v = $urandom;
        end
        pick = $urandom_range(0, 99);
        if (pick < 85) begin
            r = $urandom_range(RADIX_MIN, RADIX_MAX);
        end else if (pick < 95) begin
            r = $urandom_range(0, 255);
        end else begin
            case ($urandom_range(0, 3))
                0: r = 0;
                1: r = 1;
                2: r = RADIX_MAX + 1;
                default: r = 255;
            endcase
        end
        pick = $urandom_range(0, 99);
        if (pick < 5) begin
            c = 0;
        end else if (pick < 15) begin
            c = $urandom_range(0, 65535);
        end else if (pick < 20) begin
            c = 65535;
        end else if (pick < 35) begin
            c = $urandom_range(1, 8);
        end else begin
            c = $urandom_range(8, 40);
        end
        queue_request(v, r, c);
    endfunction

    // Expand one request into the result items it must produce.
    function automatic void convert_to_chars(input t_in_item req);
        logic [WORD_BITS-1:0] num;
        logic [WORD_BITS-1:0] base;
        int                   dig[64];
        int                   count;
        t_out_item            res;
        num   = WORD_BITS'(req.value);
        base  = WORD_BITS'(req.radix);
        count = 0;
        res   = '0;
        res.last = 1'b1;
        if (req.radix < RADIX_MIN || req.radix > RADIX_MAX) begin
            res.status = STATUS_BAD_RADIX;
            expected_chars.push_back(res);
            return;
        end
        if (req.capacity == 16'd0) begin
            res.status = STATUS_OK;
            expected_chars.push_back(res);
            return;
        end
        do begin
            dig[count] = int'(num % base);
            num        = num / base;
            count++;
        end while (num != '0 && count < 64);
        if (count > int'(req.capacity)) begin
            res.status = STATUS_OVERFLOW;
            expected_chars.push_back(res);
            return;
        end
        for (int i = count - 1; i >= 0; i--) begin
            res.char_code = (dig[i] < 10) ? ASCII_ZERO + 8'(dig[i])
                                          : ASCII_A + 8'(dig[i] - 10);
            res.has_char  = 1'b1;
            res.last      = (i == 0);
            res.status    = STATUS_OK;
            expected_chars.push_back(res);
        end
    endfunction

    function automatic void check_field(input string name, input int exp_v, input int act_v);
        if (exp_v != act_v) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, exp_v, act_v);
            mismatches++;
        end
    endfunction

    // Accept side: record each input item and the result items it owes.
    always @(posedge i_clk) begin
        item_taken <= i_rst_n && push && !full;
        if (i_rst_n && push && !full) begin
            convert_to_chars(pending_requests.pop_front());
            items_sent++;
        end
    end

    always @(posedge i_clk) begin
        t_out_item exp_item;
        if (i_rst_n && pop && !empty) begin
            if (expected_chars.size() == 0) begin
                $display("%0t: unexpected result item %h", $time, o_item);
                mismatches++;
            end else begin
                exp_item = expected_chars.pop_front();
                check_field("char_code", exp_item.char_code, o_item.char_code);
                check_field("has_char", exp_item.has_char, o_item.has_char);
                check_field("last", exp_item.last, o_item.last);
                check_field("status", exp_item.status, o_item.status);
            end
        end
    end

    always @(negedge i_clk) begin
        int idle_pct;
        idle_pct = (items_sent < total_items / 3) ? 14 :
                   (items_sent < 2 * total_items / 3) ? 77 : 0;
        if (!i_rst_n) begin
            push <= 1'b0;
        end else if (push && !item_taken) begin
            // hold the offered item
        end else if (pending_requests.size() > 0 && $urandom_range(0, 99) >= idle_pct) begin
            push   <= 1'b1;
            i_item <= pending_requests[0];
        end else begin
            push <= 1'b0;
        end
    end

    always @(negedge i_clk) begin
        int idle_pct;
        idle_pct = (items_sent < total_items / 3) ? 77 :
                   (items_sent < 2 * total_items / 3) ? 14 : 0;
        if (!hold_done && items_sent >= total_items / 3 + 10) begin
            hold_done = 1'b1;
            hold_left = HOLD_CYCLES;
        end
        if (!i_rst_n) begin
            pop <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left--;
            pop <= 1'b0;
        end else begin
            pop <= ($urandom_range(0, 99) >= idle_pct);
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    initial begin
        queue_request(0, 10, 1);
        queue_request(32'h7FFF_FFFF, 10, 10);
        queue_request(32'h8000_0000, 16, 8);
        queue_request(-1, 2, 32);
        queue_request(-1, 36, 7);
        queue_request(35, 36, 1);
        queue_request(9, 10, 1);
        queue_request(10, 11, 1);
        queue_request(123, 0, 5);
        queue_request(123, 1, 5);
        queue_request(123, 37, 5);
        queue_request(123, 255, 0);
        queue_request(123, 10, 0);
        queue_request(-1, 2, 31);
        queue_request(255, 16, 2);
        queue_request(256, 16, 2);
        queue_request(42, 2, 65535);
        queue_request(12345678, 8, 16'hFFFF);
        queue_request(-2, 3, 21);
        queue_request(-2147483647, 7, 12);
        for (int n = 0; n < RANDOM_REQUESTS; n++) begin
            queue_random_request();
        end
        total_items = pending_requests.size();

        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        while (items_sent < total_items) @(posedge i_clk);
        while (expected_chars.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (mismatches == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
